### rtl/core/bcba_pkg.sv
package bcba_pkg;

  localparam int DEF_NUM_BLOCKS = 256;

  // one memory word holds the free bits of eight blocks
  localparam int ROW_W  = 8;
  localparam int ROW_SH = 3;

  localparam int KIND_W   = 2;
  localparam int LEN_W    = 9;
  localparam int WSTART_W = 8;
  localparam int WEND_W   = 9;
  localparam int FSTART_W = 8;
  localparam int RSTART_W = 8;

  localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FORMAT = 2'd2;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_NOSPACE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPD,
    ST_RESP
  } state_t;

endpackage

### rtl/core/bcba_ram.sv
module bcba_ram import bcba_pkg::*; #(
  parameter int DEPTH = DEF_NUM_BLOCKS / ROW_W,
  parameter int AW    = 5
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [ROW_W-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [ROW_W-1:0] wr_data
);

  logic [ROW_W-1:0] mem [DEPTH];
  logic [ROW_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/core/bcba_row_unit.sv
module bcba_row_unit import bcba_pkg::*; #(
  parameter int AW = 5,
  parameter int SW = 11
) (
  input  logic [ROW_W-1:0] data,
  input  logic [AW-1:0]    row,
  input  logic [SW-1:0]    lo,
  input  logic [SW-1:0]    hi,
  input  logic [LEN_W-1:0] len,
  input  logic [LEN_W-1:0] cnt_in,
  input  logic [SW-1:0]    first_in,
  output logic [LEN_W-1:0] cnt_out,
  output logic [SW-1:0]    first_out,
  output logic             hit,
  output logic [ROW_W-1:0] mask
);

  // walk the eight blocks of one word, lowest address first
  always_comb begin
    logic [SW-1:0]    b;
    logic             in_rng;
    logic [LEN_W-1:0] cnt;
    logic [SW-1:0]    fst;
    logic             found;
    cnt   = cnt_in;
    fst   = first_in;
    found = 1'b0;
    mask  = '0;
    b     = '0;
    in_rng = 1'b0;
    for (int i = 0; i < ROW_W; i++) begin
      b       = SW'({row, ROW_SH'(i)});
      in_rng  = (b >= lo) && (b < hi);
      mask[i] = in_rng;
      if (!found && in_rng) begin
        if (data[i]) begin
          if (cnt == '0) begin
            fst = b;
          end
          cnt = cnt + 1'b1;
          if (cnt == len) begin
            found = 1'b1;
          end
        end else begin
          cnt = '0;
        end
      end
    end
    cnt_out   = cnt;
    first_out = fst;
    hit       = found;
  end

endmodule

### rtl/core/bitmap_contiguous_block_allocator.sv
// First-fit contiguous block allocator over a free bitmap (1 = free), one bit per
// block, kept in a RAM of 8-bit words. One word is handled per cycle by a shared row
// unit, streamed from a registered RAM read. An allocate scans the words covering
// [window_start, min(window_end, NUM_BLOCKS)) until the first fitting run, then
// clears that run word by word. A free sets its clipped range word by word; a format
// rewrites every word. After reset the map is swept to all free with in_stall high.
// One word is in flight at a time; a new word is accepted once the previous one is
// done, even while its result still waits on out_stall.
module bitmap_contiguous_block_allocator import bcba_pkg::*; #(
  parameter int NUM_BLOCKS = DEF_NUM_BLOCKS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [KIND_W-1:0]   in_kind,
  input  logic [LEN_W-1:0]    in_run_length,
  input  logic [WSTART_W-1:0] in_window_start,
  input  logic [WEND_W-1:0]   in_window_end,
  input  logic [FSTART_W-1:0] in_free_start,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_status,
  output logic [RSTART_W-1:0] out_run_start
);

  localparam int ROWS = (NUM_BLOCKS + ROW_W - 1) / ROW_W;
  localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int IW   = AW + ROW_SH;
  localparam int SW   = (IW + 1 > 11) ? IW + 1 : 11;
  localparam logic [SW-1:0] NB_S         = SW'(NUM_BLOCKS);
  localparam logic [AW-1:0] LAST_ROW_ALL = AW'(ROWS - 1);

  function automatic logic [AW:0] row_of(input logic [SW-1:0] x);
    row_of = (AW+1)'(x >> ROW_SH);
  endfunction

  function automatic logic [AW-1:0] last_row_of(input logic [SW-1:0] x_excl);
    last_row_of = AW'((x_excl - 1'b1) >> ROW_SH);
  endfunction

  state_t state_r, state_nxt;

  logic [AW:0]           rd_row_r, rd_row_nxt;
  logic [AW-1:0]         last_row_r, last_row_nxt;
  logic                  proc_valid_r, proc_valid_nxt;
  logic [AW-1:0]         proc_row_r, proc_row_nxt;
  logic [SW-1:0]         rng_lo_r, rng_lo_nxt;
  logic [SW-1:0]         rng_hi_r, rng_hi_nxt;
  logic                  set_r, set_nxt;
  logic                  upd_resp_r, upd_resp_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic [LEN_W-1:0]      len_r, len_nxt;
  logic [LEN_W-1:0]      cnt_r, cnt_nxt;
  logic [SW-1:0]         first_r, first_nxt;
  logic                  res_status_r, res_status_nxt;
  logic [RSTART_W-1:0]   res_start_r, res_start_nxt;
  logic                  out_status_r, out_status_nxt;
  logic [RSTART_W-1:0]   out_run_start_r, out_run_start_nxt;

  logic                  accept;
  logic                  issue;
  logic                  proc_last;
  logic                  resp_go;
  logic                  out_fire;
  logic [SW-1:0]         wlo_s, whi_s, whi_clip;
  logic [SW-1:0]         fst_s, fend_s, fend_clip;
  logic [SW-1:0]         mark_hi;
  logic                  alloc_empty;
  logic                  free_empty;

  logic [ROW_W-1:0]      rd_data;
  logic                  wr_en;
  logic [ROW_W-1:0]      wr_data;
  logic [LEN_W-1:0]      ru_cnt;
  logic [SW-1:0]         ru_first;
  logic                  ru_hit;
  logic [ROW_W-1:0]      ru_mask;

  bcba_ram #(
    .DEPTH (ROWS),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .rd_en   (issue),
    .rd_addr (rd_row_r[AW-1:0]),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (proc_row_r),
    .wr_data (wr_data)
  );

  bcba_row_unit #(
    .AW (AW),
    .SW (SW)
  ) u_row (
    .data      (rd_data),
    .row       (proc_row_r),
    .lo        (rng_lo_r),
    .hi        (rng_hi_r),
    .len       (len_r),
    .cnt_in    (cnt_r),
    .first_in  (first_r),
    .cnt_out   (ru_cnt),
    .first_out (ru_first),
    .hit       (ru_hit),
    .mask      (ru_mask)
  );

  assign in_stall      = (state_r != ST_IDLE);
  assign accept        = in_valid && !in_stall;
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_run_start = out_run_start_r;
  assign out_fire      = out_valid_r && !out_stall;
  assign resp_go       = (state_r == ST_RESP) && (!out_valid_r || !out_stall);

  assign issue     = ((state_r == ST_SCAN) || (state_r == ST_UPD)) &&
                     (rd_row_r <= {1'b0, last_row_r});
  assign proc_last = proc_valid_r && (proc_row_r == last_row_r);

  assign wr_en   = (state_r == ST_UPD) && proc_valid_r;
  assign wr_data = set_r ? (rd_data | ru_mask) : (rd_data & ~ru_mask);

  assign wlo_s       = SW'(in_window_start);
  assign whi_s       = SW'(in_window_end);
  assign whi_clip    = (whi_s > NB_S) ? NB_S : whi_s;
  assign fst_s       = SW'(in_free_start);
  assign fend_s      = fst_s + SW'(in_run_length);
  assign fend_clip   = (fend_s > NB_S) ? NB_S : fend_s;
  assign mark_hi     = ru_first + SW'(len_r);
  assign alloc_empty = (in_run_length == '0) || (wlo_s >= whi_clip);
  assign free_empty  = (fst_s >= fend_clip);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_kind)
            KIND_ALLOC:  state_nxt = alloc_empty ? ST_RESP : ST_SCAN;
            KIND_FREE:   state_nxt = free_empty ? ST_RESP : ST_UPD;
            KIND_FORMAT: state_nxt = ST_UPD;
            default:     state_nxt = ST_RESP;
          endcase
        end
      end
      ST_SCAN: begin
        if (proc_valid_r && ru_hit) begin
          state_nxt = ST_UPD;
        end else if (proc_last) begin
          state_nxt = ST_RESP;
        end
      end
      ST_UPD: begin
        if (proc_last) begin
          state_nxt = upd_resp_r ? ST_RESP : ST_IDLE;
        end
      end
      ST_RESP: begin
        if (resp_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    rd_row_nxt     = issue ? rd_row_r + 1'b1 : rd_row_r;
    last_row_nxt   = last_row_r;
    proc_valid_nxt = issue;
    proc_row_nxt   = rd_row_r[AW-1:0];
    rng_lo_nxt     = rng_lo_r;
    rng_hi_nxt     = rng_hi_r;
    set_nxt        = set_r;
    upd_resp_nxt   = upd_resp_r;
    len_nxt        = len_r;
    cnt_nxt        = cnt_r;
    first_nxt      = first_r;
    res_status_nxt = res_status_r;
    res_start_nxt  = res_start_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_status_nxt = STATUS_OK;
          res_start_nxt  = '0;
          upd_resp_nxt   = 1'b1;
          len_nxt        = in_run_length;
          cnt_nxt        = '0;
          first_nxt      = '0;
          case (in_kind)
            KIND_ALLOC: begin
              res_status_nxt = STATUS_NOSPACE;
              rng_lo_nxt     = wlo_s;
              rng_hi_nxt     = whi_clip;
              rd_row_nxt     = row_of(wlo_s);
              last_row_nxt   = last_row_of(whi_clip);
            end
            KIND_FREE: begin
              set_nxt      = 1'b1;
              rng_lo_nxt   = fst_s;
              rng_hi_nxt   = fend_clip;
              rd_row_nxt   = row_of(fst_s);
              last_row_nxt = last_row_of(fend_clip);
            end
            KIND_FORMAT: begin
              set_nxt      = 1'b1;
              rng_lo_nxt   = '0;
              rng_hi_nxt   = NB_S;
              rd_row_nxt   = '0;
              last_row_nxt = LAST_ROW_ALL;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (proc_valid_r) begin
          cnt_nxt   = ru_cnt;
          first_nxt = ru_first;
          if (ru_hit) begin
            // switch to clearing the found run; drop the word still in flight
            set_nxt        = 1'b0;
            rng_lo_nxt     = ru_first;
            rng_hi_nxt     = mark_hi;
            rd_row_nxt     = row_of(ru_first);
            last_row_nxt   = last_row_of(mark_hi);
            proc_valid_nxt = 1'b0;
            res_status_nxt = STATUS_OK;
            res_start_nxt  = ru_first[RSTART_W-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt     = out_valid_r;
    out_status_nxt    = out_status_r;
    out_run_start_nxt = out_run_start_r;
    if (resp_go) begin
      out_valid_nxt     = 1'b1;
      out_status_nxt    = res_status_r;
      out_run_start_nxt = res_start_r;
    end else if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
  end

  // reset starts a sweep that marks every block free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_UPD;
      rd_row_r     <= '0;
      last_row_r   <= LAST_ROW_ALL;
      proc_valid_r <= 1'b0;
      rng_lo_r     <= '0;
      rng_hi_r     <= NB_S;
      set_r        <= 1'b1;
      upd_resp_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rd_row_r     <= rd_row_nxt;
      last_row_r   <= last_row_nxt;
      proc_valid_r <= proc_valid_nxt;
      rng_lo_r     <= rng_lo_nxt;
      rng_hi_r     <= rng_hi_nxt;
      set_r        <= set_nxt;
      upd_resp_r   <= upd_resp_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    proc_row_r      <= proc_row_nxt;
    len_r           <= len_nxt;
    cnt_r           <= cnt_nxt;
    first_r         <= first_nxt;
    res_status_r    <= res_status_nxt;
    res_start_r     <= res_start_nxt;
    out_status_r    <= out_status_nxt;
    out_run_start_r <= out_run_start_nxt;
  end

endmodule

### verif/bcba_tb_pkg.sv
`timescale 1ns / 100ps

package bcba_tb_pkg;
  import bcba_pkg::*;

  typedef struct packed {
    logic                status;
    logic [RSTART_W-1:0] run_start;
  } alloc_reply_t;

  class free_map_scoreboard;
    bit [DEF_NUM_BLOCKS-1:0] free_map;
    alloc_reply_t            predicted_replies[$];
    int                      mismatch_count;

    function new();
      free_map       = '1;
      mismatch_count = 0;
    endfunction

    function int outstanding();
      return predicted_replies.size();
    endfunction

    task report(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatch_count++;
    endtask

    // Update the map as the block should and queue the reply it owes for this word.
    function void note_request(input logic [KIND_W-1:0]   kind,
                               input logic [LEN_W-1:0]    len,
                               input logic [WSTART_W-1:0] w_start,
                               input logic [WEND_W-1:0]   w_end,
                               input logic [FSTART_W-1:0] f_start);
      alloc_reply_t reply;
      int           scan_end;
      int           range_end;
      int           run;
      int           first;
      bit           found;
      reply.status    = STATUS_OK;
      reply.run_start = '0;
      case (kind)
        KIND_ALLOC: begin
          reply.status = STATUS_NOSPACE;
          scan_end = (int'(w_end) > DEF_NUM_BLOCKS) ? DEF_NUM_BLOCKS : int'(w_end);
          run   = 0;
          first = 0;
          found = 1'b0;
          if (len != '0) begin
            for (int b = int'(w_start); b < scan_end && !found; b++) begin
              if (free_map[b]) begin
                if (run == 0) first = b;
                run++;
                if (run == int'(len)) found = 1'b1;
              end else begin
                run = 0;
              end
            end
          end
          if (found) begin
            for (int b = first; b < first + int'(len); b++) free_map[b] = 1'b0;
            reply.status    = STATUS_OK;
            reply.run_start = first[RSTART_W-1:0];
          end
        end
        KIND_FREE: begin
          // clip at the last block
          range_end = int'(f_start) + int'(len);
          if (range_end > DEF_NUM_BLOCKS) range_end = DEF_NUM_BLOCKS;
          for (int b = int'(f_start); b < range_end; b++) free_map[b] = 1'b1;
        end
        KIND_FORMAT: free_map = '1;
        default: ;
      endcase
      predicted_replies.push_back(reply);
    endfunction

    task check_reply(input logic status, input logic [RSTART_W-1:0] run_start);
      alloc_reply_t want;
      if (predicted_replies.size() == 0) begin
        report($sformatf("reply word status=%0b run_start=%0d with nothing outstanding",
                         status, run_start));
      end else begin
        want = predicted_replies.pop_front();
        if (status !== want.status)
          report($sformatf("status %0b, predicted %0b", status, want.status));
        if (run_start !== want.run_start)
          report($sformatf("run_start %0d, predicted %0d", run_start, want.run_start));
      end
    endtask
  endclass

endpackage

### verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import bcba_pkg::*;
  import bcba_tb_pkg::*;

  localparam int RANDOM_WORDS = 930;

  // kind value that the block treats as a no-op
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  logic                clk;
  logic                rst_n           = 1'b0;
  logic                in_valid        = 1'b0;
  logic                in_stall;
  logic [KIND_W-1:0]   in_kind         = KIND_ALLOC;
  logic [LEN_W-1:0]    in_run_length   = '0;
  logic [WSTART_W-1:0] in_window_start = '0;
  logic [WEND_W-1:0]   in_window_end   = '0;
  logic [FSTART_W-1:0] in_free_start   = '0;
  logic                out_valid;
  logic                out_stall       = 1'b0;
  logic                out_status;
  logic [RSTART_W-1:0] out_run_start;

  bit                  idle_on = 1'b1;
  free_map_scoreboard  sb = new();

  bitmap_contiguous_block_allocator dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_run_length  (in_run_length),
    .in_window_start(in_window_start),
    .in_window_end  (in_window_end),
    .in_free_start  (in_free_start),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_run_start  (out_run_start)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // check the reply before noting a new word, so a stray reply is never matched to it
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_reply(out_status, out_run_start);
    if (rst_n && in_valid && !in_stall)
      sb.note_request(in_kind, in_run_length, in_window_start, in_window_end, in_free_start);
  end

  // receiver: stall in random bursts while idling is on
  initial begin
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_word(input logic [KIND_W-1:0]   kind,
                           input logic [LEN_W-1:0]    len,
                           input logic [WSTART_W-1:0] w_start,
                           input logic [WEND_W-1:0]   w_end,
                           input logic [FSTART_W-1:0] f_start);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_kind         <= kind;
    in_run_length   <= len;
    in_window_start <= w_start;
    in_window_end   <= w_end;
    in_free_start   <= f_start;
    do @(posedge clk); while (in_stall);
  endtask

  // hold off the sender until every reply is back
  task automatic drain_replies();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  function automatic logic [LEN_W-1:0] pick_length();
    int p;
    p = $urandom_range(0, 99);
    if (p < 70) return LEN_W'($urandom_range(1, 8));
    if (p < 90) return LEN_W'($urandom_range(9, 48));
    if (p < 97) return LEN_W'($urandom_range(49, 200));
    return LEN_W'($urandom_range(0, 511));
  endfunction

  task automatic directed_words();
    send_word(KIND_ALLOC, 9'd0, 8'd0, 9'd256, 8'd0);
    send_word(KIND_ALLOC, 9'd1, 8'd0, 9'd256, 8'd0);
    send_word(KIND_ALLOC, 9'd256, 8'd0, 9'd256, 8'd0);
    send_word(KIND_ALLOC, 9'd255, 8'd0, 9'd511, 8'd0);
    send_word(KIND_ALLOC, 9'd1, 8'd0, 9'd256, 8'd0);
    send_word(KIND_FREE, 9'd511, 8'd0, 9'd0, 8'd255);
    send_word(KIND_ALLOC, 9'd1, 8'd255, 9'd256, 8'd0);
    send_word(KIND_FREE, 9'd0, 8'd0, 9'd0, 8'd0);
    send_word(KIND_SPARE, 9'd511, 8'd255, 9'd511, 8'd255);
    send_word(KIND_FORMAT, 9'd0, 8'd0, 9'd0, 8'd0);
    send_word(KIND_ALLOC, 9'd256, 8'd0, 9'd256, 8'd0);
    send_word(KIND_FORMAT, 9'd511, 8'd255, 9'd511, 8'd255);
    send_word(KIND_ALLOC, 9'd4, 8'd100, 9'd50, 8'd0);
    send_word(KIND_ALLOC, 9'd1, 8'd10, 9'd10, 8'd0);
    send_word(KIND_ALLOC, 9'd6, 8'd250, 9'd256, 8'd0);
    send_word(KIND_ALLOC, 9'd1, 8'd250, 9'd256, 8'd0);
    send_word(KIND_FREE, 9'd2, 8'd0, 9'd0, 8'd252);
    send_word(KIND_ALLOC, 9'd3, 8'd0, 9'd256, 8'd0);
    send_word(KIND_ALLOC, 9'd2, 8'd200, 9'd256, 8'd0);
    send_word(KIND_FREE, 9'd100, 8'd0, 9'd0, 8'd200);
    send_word(KIND_ALLOC, 9'd511, 8'd0, 9'd511, 8'd0);
    send_word(KIND_ALLOC, 9'd10, 8'd3, 9'd13, 8'd0);
    send_word(KIND_ALLOC, 9'd11, 8'd0, 9'd14, 8'd0);
    send_word(KIND_FORMAT, 9'd0, 8'd0, 9'd0, 8'd0);
  endtask

  task automatic random_words(input int count);
    int                  sel;
    logic [WSTART_W-1:0] w_start;
    logic [WEND_W-1:0]   w_end;
    for (int i = 0; i < count; i++) begin
      if (i == count - 150) idle_on = 1'b0;
      if (i == 400) drain_replies();
      sel     = $urandom_range(0, 99);
      w_start = ($urandom_range(0, 9) < 7) ? '0 : WSTART_W'($urandom_range(0, 255));
      w_end   = ($urandom_range(0, 9) < 7) ? WEND_W'(DEF_NUM_BLOCKS)
                                           : WEND_W'($urandom_range(0, 511));
      if (sel < 50)
        send_word(KIND_ALLOC, pick_length(), w_start, w_end, FSTART_W'($urandom));
      else if (sel < 88)
        send_word(KIND_FREE, pick_length(), WSTART_W'($urandom), WEND_W'($urandom),
                  FSTART_W'($urandom_range(0, 255)));
      else if (sel < 91)
        send_word(KIND_FORMAT, LEN_W'($urandom), WSTART_W'($urandom), WEND_W'($urandom),
                  FSTART_W'($urandom));
      else if (sel < 93)
        send_word(KIND_SPARE, LEN_W'($urandom), WSTART_W'($urandom), WEND_W'($urandom),
                  FSTART_W'($urandom));
      else
        send_word(KIND_ALLOC, LEN_W'($urandom), WSTART_W'($urandom), WEND_W'($urandom),
                  FSTART_W'($urandom));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    directed_words();
    random_words(RANDOM_WORDS);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.mismatch_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
